// ===== rtl/srr_pkg.sv =====
// Shared types and codes for the selective-repeat receiver.
// Imported by the slot store, the receiver top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package srr_pkg;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_DELIV = 3'b100
  } srr_state_e;

  // Result kinds on the output channel
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Read request from the sequencer to the slot store
  typedef struct packed {
    logic rd_en;  // issue a read this cycle
    logic fwd;    // take the data being written instead of the array
  } srr_rd_ctl_t;

endpackage

// ===== rtl/selective_repeat_receiver_unit.sv =====
// Selective-repeat ARQ receiver: window check, payload buffering, in-order delivery.
// Depends on srr_pkg and srr_slot_store.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid_i / in_ready_o): one data packet per request, with
//   its sequence number, payload word and checksum flag. A packet is taken
//   only while the sequencer is idle; a corrupt packet is dropped on the spot.
//   Output channel (out_valid_o / out_ready_i): one result per request. A good
//   packet first yields an acknowledgement, then, when it is inside the window,
//   the in-order run of buffered payloads starting at the window base.
//   last_result_o marks the final result of each packet.
// Timing
//   Corrupt packet: dropped on acceptance. Good packet: accepted in ST_IDLE, then
//   ST_EVAL emits the ack and, for an in-window packet, writes the slot RAM, then
//   ST_DELIV delivers the buffered payloads (up to WIN_SLOTS). The rate is set by the single read
//   port of the slot RAM, which yields one payload per cycle while out_ready_i is high.
//   The next packet is accepted while the last result still waits in the
//   output register.
// Reset
//   Clears the window base, the filled flags and the sequencer; the slot RAM
//   needs no clearing since a slot is read only after it was filled.
// Stall
//   A low out_ready_i holds a pending result and freezes ST_EVAL and ST_DELIV; ST_IDLE still accepts packets.

module selective_repeat_receiver_unit
  import srr_pkg::*;
#(
  parameter int WIN_SLOTS    = 4,
  parameter int SEQ_BITS     = 3,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SEQ_BITS-1:0]     sequence_number_i,
  input  logic [PAYLOAD_BITS-1:0] payload_word_i,
  input  logic                    checksum_ok_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    result_kind_o,
  output logic [SEQ_BITS-1:0]     ack_number_o,
  output logic [PAYLOAD_BITS-1:0] delivered_payload_o,
  output logic                    last_result_o
);

  localparam int SEQ_SPACE = 2 ** SEQ_BITS;
  localparam int SLOT_W    = (WIN_SLOTS > 1) ? $clog2(WIN_SLOTS) : 1;
  localparam int WIN_LIM_I = (WIN_SLOTS >= SEQ_SPACE) ? SEQ_SPACE : WIN_SLOTS;
  localparam logic [SEQ_BITS:0] WIN_LIM = (SEQ_BITS + 1)'(WIN_LIM_I);

  srr_state_e state_q, state_d;

  logic [SEQ_BITS-1:0]     base_q, base_d;
  logic [WIN_SLOTS-1:0]    filled_q, filled_d;
  logic [SEQ_BITS-1:0]     seq_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  logic                    out_valid_q, out_valid_d;
  logic                    kind_q, kind_d;
  logic [SEQ_BITS-1:0]     ack_q, ack_d;
  logic [PAYLOAD_BITS-1:0] dpay_q, dpay_d;
  logic                    last_q, last_d;

  logic                    in_fire;
  logic                    out_free;
  logic                    out_load;
  logic [SLOT_W-1:0]       slot_lut [SEQ_SPACE];
  logic [SEQ_BITS-1:0]     offset;
  logic                    in_win;
  logic [SLOT_W-1:0]       pkt_slot;
  logic [SLOT_W-1:0]       base_slot;
  logic [SEQ_BITS-1:0]     next_base;
  logic [SLOT_W-1:0]       next_slot;
  logic                    more;

  logic                    wr_en;
  srr_rd_ctl_t             rd_ctl;
  logic [SLOT_W-1:0]       rd_slot;
  logic [PAYLOAD_BITS-1:0] rd_data;

  // Sequence number to slot index table
  for (genvar g = 0; g < SEQ_SPACE; g++) begin : g_slot_lut
    assign slot_lut[g] = SLOT_W'(g % WIN_SLOTS);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign offset    = seq_q - base_q;
  assign in_win    = {1'b0, offset} < WIN_LIM;
  assign pkt_slot  = slot_lut[seq_q];
  assign base_slot = slot_lut[base_q];
  assign next_base = base_q + SEQ_BITS'(1);
  assign next_slot = slot_lut[next_base];

  // Sequencer: evaluate the packet, then walk the in-order run
  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    filled_d = filled_q;
    out_load = 1'b0;
    kind_d   = kind_q;
    ack_d    = ack_q;
    dpay_d   = dpay_q;
    last_d   = last_q;
    wr_en    = 1'b0;
    rd_ctl   = '0;
    rd_slot  = base_slot;
    more     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && checksum_ok_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_ACK;
          ack_d    = seq_q;
          dpay_d   = '0;
          if (in_win) begin
            wr_en              = 1'b1;
            filled_d[pkt_slot] = 1'b1;
            more   = filled_q[base_slot] || (pkt_slot == base_slot);
            rd_ctl.rd_en = more;
            rd_ctl.fwd   = (pkt_slot == base_slot);
            state_d      = more ? ST_DELIV : ST_IDLE;
          end else begin
            state_d = ST_IDLE;
          end
          last_d = !more;
        end
      end
      ST_DELIV: begin
        if (out_free) begin
          out_load            = 1'b1;
          kind_d              = KIND_DATA;
          ack_d               = '0;
          dpay_d              = rd_data;
          filled_d[base_slot] = 1'b0;
          base_d              = next_base;
          more         = filled_q[next_slot] && (next_slot != base_slot);
          last_d       = !more;
          rd_ctl.rd_en = more;
          rd_slot      = next_slot;
          state_d      = more ? ST_DELIV : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the packet and the result fields
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seq_q <= sequence_number_i;
      pay_q <= payload_word_i;
    end
    if (out_load) begin
      kind_q <= kind_d;
      ack_q  <= ack_d;
      dpay_q <= dpay_d;
      last_q <= last_d;
    end
  end

  srr_slot_store #(
    .WIN_SLOTS    (WIN_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SLOT_W       (SLOT_W)
  ) u_slot_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_slot_i (pkt_slot),
    .wr_data_i (pay_q),
    .rd_ctl_i  (rd_ctl),
    .rd_slot_i (rd_slot),
    .rd_data_o (rd_data)
  );

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = kind_q;
  assign ack_number_o        = ack_q;
  assign delivered_payload_o = dpay_q;
  assign last_result_o       = last_q;

  // The slot under the window base is filled whenever a delivery is pending
  a_deliv_filled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIV) |-> filled_q[base_slot])
    else $error("delivery pending on an empty slot");

  // Each delivery advances the window base by one
  a_base_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIV && out_free) |=> (base_q == $past(next_base)))
    else $error("window base did not advance on delivery");

  // A delivered slot is released
  a_slot_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIV && out_free) |=> !filled_q[$past(base_slot)])
    else $error("delivered slot still marked filled");

  // The sequencer takes no packet while it evaluates or delivers the last one
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL || state_q == ST_DELIV) |-> !in_ready_o)
    else $error("packet accepted during evaluation or delivery");

endmodule

// ===== rtl/srr_slot_store.sv =====
// Payload buffer of the receive window: one synchronous RAM with a registered read port.
// Forwards the word being written when the read request sets fwd. Uses srr_pkg.
`timescale 1ns / 1ps

module srr_slot_store
  import srr_pkg::*;
#(
  parameter int WIN_SLOTS    = 4,
  parameter int PAYLOAD_BITS = 64,
  parameter int SLOT_W       = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [SLOT_W-1:0]       wr_slot_i,
  input  logic [PAYLOAD_BITS-1:0] wr_data_i,
  input  srr_rd_ctl_t             rd_ctl_i,
  input  logic [SLOT_W-1:0]       rd_slot_i,
  output logic [PAYLOAD_BITS-1:0] rd_data_o
);

  logic [PAYLOAD_BITS-1:0] mem_q [WIN_SLOTS];
  logic [PAYLOAD_BITS-1:0] rd_q;
  logic [PAYLOAD_BITS-1:0] fwd_data_q;
  logic                    fwd_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_slot_i] <= wr_data_i;
    end
    if (rd_ctl_i.rd_en) begin
      rd_q <= mem_q[rd_slot_i];
    end
  end

  // Capture the bypass word alongside the read
  always_ff @(posedge clk_i) begin
    if (rd_ctl_i.rd_en && rd_ctl_i.fwd) begin
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_ctl_i.rd_en) begin
      fwd_q <= rd_ctl_i.fwd;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for selective_repeat_receiver_unit.
// Builds its own window/slot predictor and compares every ack and delivery in order.
// Depends on srr_pkg and the receiver RTL only.
`timescale 1ns / 1ps

module tb_top;
  import srr_pkg::*;

  localparam int WIN          = 4;
  localparam int SEQ_W        = 3;
  localparam int PAY_W        = 64;
  localparam int RESET_CYCLES = 10;
  localparam int TAIL_CYCLES  = 20;
  localparam int SHOW_LIMIT   = 10;
  localparam int ITEMS_PHASE  = 100;

  localparam logic [PAY_W-1:0] ALL_ONES = {PAY_W{1'b1}};
  localparam logic [PAY_W-1:0] ALT_A    = 64'hA5A5_A5A5_A5A5_A5A5;
  localparam logic [PAY_W-1:0] ALT_5    = 64'h5A5A_5A5A_5A5A_5A5A;

  // One result as it appears on the output channel
  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] ack;
    logic [PAY_W-1:0] payload;
    logic             last;
  } rx_result_t;

  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             in_valid_i        = 1'b0;
  logic             in_ready_o;
  logic [SEQ_W-1:0] sequence_number_i = '0;
  logic [PAY_W-1:0] payload_word_i    = '0;
  logic             checksum_ok_i     = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i       = 1'b0;
  logic             result_kind_o;
  logic [SEQ_W-1:0] ack_number_o;
  logic [PAY_W-1:0] delivered_payload_o;
  logic             last_result_o;

  // Receive window as the block should hold it
  logic [SEQ_W-1:0] win_base  = '0;
  logic [WIN-1:0]   slot_full = '0;
  logic [PAY_W-1:0] slot_word [WIN];

  rx_result_t ack_deliver_q [$];
  int         mismatches = 0;
  int         idle_pct   = 0;
  int         stall_pct  = 0;

  selective_repeat_receiver_unit #(
    .WIN_SLOTS   (WIN),
    .SEQ_BITS    (SEQ_W),
    .PAYLOAD_BITS(PAY_W)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sequence_number_i  (sequence_number_i),
    .payload_word_i     (payload_word_i),
    .checksum_ok_i      (checksum_ok_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .ack_number_o       (ack_number_o),
    .delivered_payload_o(delivered_payload_o),
    .last_result_o      (last_result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Update the window for one accepted packet and queue the ack and deliveries
  function automatic void window_receive(input logic [SEQ_W-1:0] seq,
                                         input logic [PAY_W-1:0] word,
                                         input logic             ok);
    logic [SEQ_W-1:0] offset;
    int               slot;
    int               d;
    rx_result_t       held;
    if (!ok) return;
    offset = seq - win_base;
    held   = {KIND_ACK, seq, {PAY_W{1'b0}}, 1'b1};
    if (offset < WIN) begin
      slot            = seq % WIN;
      slot_full[slot] = 1'b1;
      slot_word[slot] = word;
      // Drain the in-order run; the previous result loses its last flag
      d    = 0;
      slot = win_base % WIN;
      while (d < WIN && slot_full[slot]) begin
        held.last = 1'b0;
        ack_deliver_q.push_back(held);
        held            = {KIND_DATA, {SEQ_W{1'b0}}, slot_word[slot], 1'b1};
        slot_full[slot] = 1'b0;
        win_base        = win_base + 1'b1;
        slot            = win_base % WIN;
        d++;
      end
    end
    ack_deliver_q.push_back(held);
  endfunction

  // Send one packet request; called in the time step of a rising edge
  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [PAY_W-1:0] word,
                             input logic ok);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i        <= 1'b1;
    sequence_number_i <= seq;
    payload_word_i    <= word;
    checksum_ok_i     <= ok;
    do @(posedge clk_i); while (!in_ready_o);
    window_receive(seq, word, ok);
  endtask

  // Compare each accepted result with the oldest one queued
  always @(posedge clk_i) begin
    rx_result_t want;
    rx_result_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      got = {result_kind_o, ack_number_o, delivered_payload_o, last_result_o};
      if (ack_deliver_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: unexpected result kind=%0b ack=%0d payload=%h last=%0b",
                   $realtime, got.kind, got.ack, got.payload, got.last);
      end else begin
        want = ack_deliver_q.pop_front();
        if (got.kind !== want.kind || got.ack !== want.ack ||
            got.payload !== want.payload || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: result differs: expected kind=%0b ack=%0d payload=%h last=%0b, %s",
                     $realtime, want.kind, want.ack, want.payload, want.last,
                     $sformatf("got kind=%0b ack=%0d payload=%h last=%0b",
                               got.kind, got.ack, got.payload, got.last));
        end
      end
    end
  end

  // Corrupt packets, including the top sequence number, leave no trace
  task automatic test_corrupt_drop();
    send_packet(3'd0, ALL_ONES, 1'b0);
    send_packet(3'd7, '0, 1'b0);
  endtask

  // Far-ahead and old packets get a bare re-ack; base moves once
  task automatic test_outside_window();
    send_packet(3'd5, ALT_A, 1'b1);
    send_packet(3'd0, '0, 1'b1);
    send_packet(3'd0, ALL_ONES, 1'b1);
    send_packet(3'd7, ALT_5, 1'b1);
  endtask

  // Buffer out of order, overwrite a repeat, then release a full window at once
  task automatic test_reorder_delivery();
    send_packet(3'd3, ALT_A, 1'b1);
    send_packet(3'd3, ALT_5, 1'b1);
    send_packet(3'd2, 64'h0123_4567_89AB_CDEF, 1'b1);
    send_packet(3'd4, 64'hFEDC_BA98_7654_3210, 1'b1);
    send_packet(3'd1, ALL_ONES, 1'b1);
  endtask

  // Window spanning the top of the sequence space, base wraps to the start
  task automatic test_window_wrap();
    send_packet(3'd7, ALL_ONES, 1'b1);
    send_packet(3'd0, ALT_A, 1'b1);
    send_packet(3'd6, '0, 1'b1);
    send_packet(3'd5, ALT_5, 1'b0);
    send_packet(3'd5, ALT_5, 1'b1);
    send_packet(3'd1, ALL_ONES, 1'b1);
  endtask

  // Mostly in-window traffic in random order, plus stray and corrupt packets
  task automatic test_random_traffic(input int idle, input int stall, input int n_good);
    int               good;
    int               pick;
    logic [SEQ_W-1:0] seq;
    logic             ok;
    idle_pct  = idle;
    stall_pct = stall;
    good      = 0;
    while (good < n_good) begin
      pick = $urandom_range(0, 99);
      ok   = (pick >= 10);
      if (pick >= 10 && pick < 80)
        seq = win_base + SEQ_W'($urandom_range(0, WIN - 1));
      else
        seq = SEQ_W'($urandom_range(0, (1 << SEQ_W) - 1));
      send_packet(seq, {$urandom, $urandom}, ok);
      if (ok) good++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corrupt_drop();
    test_outside_window();
    test_reorder_delivery();
    test_window_wrap();
    test_random_traffic(0, 0, ITEMS_PHASE);
    test_random_traffic(59, 0, ITEMS_PHASE);
    test_random_traffic(0, 59, ITEMS_PHASE);
    test_random_traffic(38, 38, ITEMS_PHASE);

    // Drop the request line, drain, then watch for stray results
    in_valid_i <= 1'b0;
    while (ack_deliver_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && ack_deliver_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/srr_pkg.sv
rtl/srr_slot_store.sv
rtl/selective_repeat_receiver_unit.sv
test/tb_top.sv
